@@ hw/rtl/lcg_pkg.sv @@
// Shared types and constants of the LiPo charge gauge.
// Holds the sequencer state type, the control bundles and the cell curve table.
// No dependencies.
package lcg_pkg;

    // Width of the shared adder: covers the 43-bit reciprocal product
    localparam int ALU_W = 44;

    // Points held in the cell curve table
    localparam int TABLE_LEN = 21;

    // Step counts of the iterative phases
    localparam logic [4:0] AVG_STEPS  = 5'd21;
    localparam logic [4:0] DIV_STEPS  = 5'd26;
    localparam logic [4:0] MUL1_STEPS = 5'd10;
    localparam logic [4:0] MUL2_STEPS = 5'd13;

    // Curve index from which the pack counts as healthy (20 % in 5 % steps)
    localparam logic [4:0] HEALTHY_IDX = 5'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_REFERENCE_MV = 2'd0;
    localparam logic [1:0] CFG_ADC_BITS     = 2'd1;
    localparam logic [1:0] CFG_DIV_NUM      = 2'd2;
    localparam logic [1:0] CFG_DIV_DEN      = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_MUL1,
        ST_DIV,
        ST_MUL2,
        ST_SCALE,
        ST_SEARCH,
        ST_OUT
    } t_state;

    // Sequencer to datapath
    typedef struct packed {
        t_state st;
        logic   last;
    } t_ctrl;

    // Datapath to sequencer
    typedef struct packed {
        logic in_fire;
        logic group_end;
        logic search_stop;
        logic out_free;
    } t_stat;

    // Sum of two neighbouring curve points, c[k] + c[k+1].
    // Curve (mV): 3270 3610 3690 3710 3730 3750 3770 3790 3800 3820 3840
    //             3850 3870 3910 3950 3980 4020 4080 4110 4150 4200
    // A voltage v lies nearer the upper point of pair k, ties going low,
    // exactly when 2v exceeds this sum.
    function automatic logic [13:0] curve_mid(input logic [4:0] k);
        logic [13:0] m;
        case (k)
            5'd0:    m = 14'd6880;
            5'd1:    m = 14'd7300;
            5'd2:    m = 14'd7400;
            5'd3:    m = 14'd7440;
            5'd4:    m = 14'd7480;
            5'd5:    m = 14'd7520;
            5'd6:    m = 14'd7560;
            5'd7:    m = 14'd7590;
            5'd8:    m = 14'd7620;
            5'd9:    m = 14'd7660;
            5'd10:   m = 14'd7690;
            5'd11:   m = 14'd7720;
            5'd12:   m = 14'd7780;
            5'd13:   m = 14'd7860;
            5'd14:   m = 14'd7930;
            5'd15:   m = 14'd8000;
            5'd16:   m = 14'd8100;
            5'd17:   m = 14'd8190;
            5'd18:   m = 14'd8260;
            5'd19:   m = 14'd8350;
            default: m = 14'h3FFF;
        endcase
        return m;
    endfunction

endpackage

@@ hw/rtl/lcg_alu.sv @@
// Shared add/subtract unit of the charge gauge.
// Used for accumulation, division steps, multiply steps and curve compares.
// Depends on lcg_pkg.
module lcg_alu import lcg_pkg::*; (
    input  logic [ALU_W-1:0] i_a,
    input  logic [ALU_W-1:0] i_b,
    input  logic             i_sub,
    output logic [ALU_W-1:0] o_res,
    output logic             o_carry
);

    logic [ALU_W-1:0] b_in;

    // Invert and add one for subtraction; carry out set means no borrow
    assign b_in = i_sub ? ~i_b : i_b;
    assign {o_carry, o_res} = {1'b0, i_a} + {1'b0, b_in} + (ALU_W + 1)'(i_sub);

endmodule

@@ hw/rtl/lcg_seq.sv @@
// Phase sequencer of the charge gauge.
// Walks accumulate, average, multiply, divide, multiply, scale, search, output.
// Depends on lcg_pkg.
module lcg_seq import lcg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    t_state     r_state, n_state;
    logic [4:0] r_step, n_step;
    logic       last;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_stat.in_fire && i_stat.group_end) n_state = ST_AVG;
            ST_AVG:    if (last) n_state = ST_MUL1;
            ST_MUL1:   if (last) n_state = ST_DIV;
            ST_DIV:    if (last) n_state = ST_MUL2;
            ST_MUL2:   if (last) n_state = ST_SCALE;
            ST_SCALE:  n_state = ST_SEARCH;
            ST_SEARCH: if (i_stat.search_stop) n_state = ST_OUT;
            ST_OUT:    if (i_stat.out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs: flag the final step of each iterative phase
    always_comb begin
        case (r_state)
            ST_AVG:  last = (r_step == AVG_STEPS - 5'd1);
            ST_DIV:  last = (r_step == DIV_STEPS - 5'd1);
            ST_MUL1: last = (r_step == MUL1_STEPS - 5'd1);
            ST_MUL2: last = (r_step == MUL2_STEPS - 5'd1);
            default: last = 1'b0;
        endcase
    end

    // Restart the step count on every phase change
    assign n_step = (n_state != r_state) ? 5'd0 : r_step + 5'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= 5'd0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_ctrl.st   = r_state;
    assign o_ctrl.last = last;

endmodule

@@ hw/rtl/lipo_charge_gauge.sv @@
// Top level of the LiPo charge gauge: ports, configuration, datapath registers.
// Instantiates lcg_seq and lcg_alu; depends on lcg_pkg.
//
// Each accepted sample is added to a running sum. The sample that closes a
// group of SAMPLES_PER_RESULT starts the result computation, during which
// o_s_tready is low: a 21-step multiply of the sum by a fixed reciprocal of
// the group size, a 10-step multiply by the divider denominator, a 26-step
// restoring divide by the divider numerator, a 13-step multiply by the
// reference, a shift and saturation step, a curve search that stops at the
// nearest curve point, then a load of the output register, which waits while
// an earlier result still sits there. Outside the computation o_s_tready is
// high. Every accumulation, multiply, divide and search step goes through the
// single shared adder. A finished result waits in the output register while
// the next group is collected. No clearing pass after reset.
module lipo_charge_gauge import lcg_pkg::*; #(
    parameter int SAMPLES_PER_RESULT = 20,
    parameter int CURVE_POINTS       = 21
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Sample stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] sample
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [15:0] voltage_mv, [22:16] percent, [23] healthy
    // Configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [12:0] i_cfg_wdata
);

    localparam int NDIV = (SAMPLES_PER_RESULT < 1) ? 1 : SAMPLES_PER_RESULT;
    localparam int NPTS = (CURVE_POINTS < 2) ? 2 :
                          ((CURVE_POINTS > TABLE_LEN) ? TABLE_LEN : CURVE_POINTS);
    localparam logic [5:0] N_DIV    = 6'(NDIV);
    localparam logic [4:0] IDX_LAST = 5'(NPTS - 1);
    // Reciprocal of the group size: the sum is below NDIV * 2^16, so a shift of
    // 16 + 2 * clog2(NDIV) with a rounded-up multiplier gives the exact quotient
    localparam int NLOG = $clog2(NDIV);
    localparam int RSH  = 16 + 2 * NLOG;
    localparam logic [21:0] RECIP_K =
        22'(((64'd1 << RSH) + 64'(NDIV) - 64'd1) / 64'(NDIV));

    t_ctrl ctrl;
    t_stat stat;

    // Configuration
    logic [12:0] r_ref;
    logic [4:0]  r_adcb;
    logic [9:0]  r_num;
    logic [9:0]  r_den;

    // Datapath
    logic [20:0] r_sum;
    logic [5:0]  r_cnt;
    logic [9:0]  r_rem;
    logic [25:0] r_q;
    logic [42:0] r_acc;
    logic [12:0] r_mplr;
    logic [15:0] r_volt;
    logic [4:0]  r_idx;

    // Output register
    logic        r_m_tvalid;
    logic [23:0] r_m_tdata;

    logic [ALU_W-1:0] alu_a, alu_b, alu_res;
    logic             alu_sub, alu_carry;

    logic        in_fire;
    logic [5:0]  cnt_inc;
    logic        group_end;
    logic        out_free;
    logic [10:0] trial;
    logic [9:0]  num_eff;
    logic [42:0] shifted;
    logic [15:0] volt_sat;
    logic        search_stop;
    logic [6:0]  pct;

    assign in_fire   = i_s_tvalid && o_s_tready;
    assign cnt_inc   = r_cnt + 6'd1;
    assign group_end = (cnt_inc >= N_DIV);
    assign out_free  = !r_m_tvalid || i_m_tready;
    assign trial     = {r_rem, r_q[25]};
    assign num_eff   = (r_num == 10'd0) ? 10'd1 : r_num;
    assign shifted   = r_acc >> r_adcb;
    assign volt_sat  = (|shifted[42:16]) ? 16'hFFFF : shifted[15:0];
    // Carry set means the midpoint sum is not below 2v: the scan ends here
    assign search_stop = (r_idx == IDX_LAST) || alu_carry;
    assign pct = {r_idx, 2'b00} + 7'(r_idx);

    assign stat.in_fire     = in_fire;
    assign stat.group_end   = group_end;
    assign stat.search_stop = search_stop;
    assign stat.out_free    = out_free;

    lcg_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    // Steer the shared adder by phase
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (ctrl.st)
            ST_IDLE: begin
                alu_a = ALU_W'(r_sum);
                alu_b = ALU_W'(i_s_tdata);
            end
            ST_AVG: begin
                alu_a = {r_acc, 1'b0};
                alu_b = r_q[25] ? ALU_W'(RECIP_K) : '0;
            end
            ST_DIV: begin
                alu_a   = ALU_W'(trial);
                alu_b   = ALU_W'(num_eff);
                alu_sub = 1'b1;
            end
            ST_MUL1, ST_MUL2: begin
                alu_a = {r_acc, 1'b0};
                alu_b = r_mplr[12] ? ALU_W'(r_q) : '0;
            end
            ST_SEARCH: begin
                alu_a   = ALU_W'(curve_mid(r_idx));
                alu_b   = ALU_W'({r_volt, 1'b0});
                alu_sub = 1'b1;
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    lcg_alu u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_res   (alu_res),
        .o_carry (alu_carry)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref  <= 13'd3300;
            r_adcb <= 5'd10;
            r_num  <= 10'd1;
            r_den  <= 10'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_REFERENCE_MV: r_ref  <= i_cfg_wdata;
                CFG_ADC_BITS:     r_adcb <= i_cfg_wdata[4:0];
                CFG_DIV_NUM:      r_num  <= i_cfg_wdata[9:0];
                CFG_DIV_DEN:      r_den  <= i_cfg_wdata[9:0];
                default:          r_ref  <= r_ref;
            endcase
        end
    end

    // Accumulate samples; close the group on the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= 21'd0;
            r_cnt <= 6'd0;
        end else if (in_fire) begin
            if (group_end) begin
                r_sum <= 21'd0;
                r_cnt <= 6'd0;
            end else begin
                r_sum <= alu_res[20:0];
                r_cnt <= cnt_inc;
            end
        end
    end

    // Iterative average, multiply, divide, scale and search
    always_ff @(posedge i_clk) begin
        case (ctrl.st)
            ST_IDLE: begin
                if (in_fire && group_end) begin
                    r_q   <= {alu_res[20:0], 5'd0};
                    r_acc <= 43'd0;
                end
            end
            ST_AVG: begin
                // Take the average from the top of the finished product
                if (ctrl.last) begin
                    r_q    <= 26'(alu_res[RSH +: 16]);
                    r_acc  <= 43'd0;
                    r_mplr <= {r_den, 3'b000};
                end else begin
                    r_acc <= alu_res[42:0];
                    r_q   <= {r_q[24:0], 1'b0};
                end
            end
            ST_DIV: begin
                r_rem <= alu_carry ? alu_res[9:0] : trial[9:0];
                r_q   <= {r_q[24:0], alu_carry};
                if (ctrl.last) begin
                    r_acc  <= 43'd0;
                    r_mplr <= r_ref;
                end
            end
            ST_MUL1, ST_MUL2: begin
                r_acc  <= alu_res[42:0];
                r_mplr <= {r_mplr[11:0], 1'b0};
                if (ctrl.last && ctrl.st == ST_MUL1) begin
                    r_q   <= alu_res[25:0];
                    r_rem <= 10'd0;
                end
            end
            ST_SCALE: begin
                r_volt <= volt_sat;
                r_idx  <= 5'd0;
            end
            ST_SEARCH: begin
                if (!search_stop) r_idx <= r_idx + 5'd1;
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    // Output register: load when free, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (ctrl.st == ST_OUT && out_free) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.st == ST_OUT && out_free) begin
            r_m_tdata <= {(r_idx >= HEALTHY_IDX), pct, r_volt};
        end
    end

    assign o_s_tready = (ctrl.st == ST_IDLE);
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    // Checks
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[22:16] <= 7'd100))
        else $error("percent out of range");

    a_healthy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[23] == (o_m_tdata[22:16] >= 7'd20)))
        else $error("healthy flag disagrees with percent");

    a_group_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && group_end) |=> (ctrl.st == ST_AVG && r_cnt == 6'd0))
        else $error("group end did not start the computation");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.st == ST_IDLE) |-> (r_cnt < N_DIV))
        else $error("sample count overran the group size");

endmodule
